@@ hdl/ipv4_datagram_fragmenter_assert.svh @@
// Assertion macros used by the IPv4 fragmenter top level.
// Depends on nothing; included by the files that carry checks.
`ifndef IPV4_DATAGRAM_FRAGMENTER_ASSERT_SVH
`define IPV4_DATAGRAM_FRAGMENTER_ASSERT_SVH

`ifndef SYNTHESIS
// Check that is skipped while reset is asserted.
`define IPV4F_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipv4 fragmenter check failed");
// Check that also holds around reset.
`define IPV4F_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ipv4 fragmenter reset check failed");
`else
`define IPV4F_ASSERT(lbl, clk, rst_n, prop)
`define IPV4F_ASSERT_RST(lbl, clk, prop)
`endif

`endif

@@ hdl/ipv4f_pkg.sv @@
// Package for the IPv4 fragmenter: result kinds, unit opcodes and word types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ipv4f_pkg;

    localparam int unsigned MaxFragmentsDefault = 64;
    localparam int unsigned InWidth  = 96;
    localparam int unsigned OutWidth = 72;

    // Result kinds as seen on tuser.
    typedef enum logic [1:0] {
        K_SEND        = 2'd0,
        K_TIME        = 2'd1,
        K_FRAG_NEEDED = 2'd2,
        K_TOO_MANY    = 2'd3
    } t_kind;

    // Operations of the shared arithmetic unit.
    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [15:0] a;
        logic [15:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] result;
        logic        borrow;
        logic        zero;
    } t_alu_rsp;

    // One result word.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] frag_length;
        logic [15:0] frag_offset;
        logic        more_out;
        logic [31:0] hop_out;
        logic        last;
    } t_result;

endpackage

@@ hdl/ipv4f_alu.sv @@
// Shared 16-bit add/subtract unit with borrow and zero flags.
// Depends on ipv4f_pkg.
`timescale 1ns / 1ps

module ipv4f_alu (
    input  ipv4f_pkg::t_alu_req i_req,
    output ipv4f_pkg::t_alu_rsp o_rsp
);

    logic [16:0] sum;

    // A subtract reports a borrow in the top bit when b exceeds a.
    always_comb begin
        if (i_req.op == ipv4f_pkg::ALU_ADD) begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end else begin
            sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end
    end

    assign o_rsp.result = sum[15:0];
    assign o_rsp.borrow = (i_req.op == ipv4f_pkg::ALU_SUB) && sum[16];
    assign o_rsp.zero   = (sum[15:0] == 16'd0);

endmodule

@@ hdl/ipv4f_out_reg.sv @@
// Output register of the IPv4 fragmenter: holds one result word for the
// master stream. Depends on ipv4f_pkg.
`timescale 1ns / 1ps

module ipv4f_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  ipv4f_pkg::t_result    i_word,
    output logic                  o_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output ipv4f_pkg::t_result    o_word
);

    logic               r_valid;
    ipv4f_pkg::t_result r_word;

    // A new word may enter when the slot is empty or is drained this cycle.
    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign o_word        = r_word;

endmodule

@@ hdl/ipv4_datagram_fragmenter.sv @@
// IPv4 datagram fragmenter top level: sequencer around one shared add/subtract
// unit. Depends on ipv4f_pkg, ipv4f_alu, ipv4f_out_reg and the assertion header.
//
// Usage:
// The slave stream takes one datagram header word per item. tdata carries, from
// bit 0 up: datagram length, header_length, offset_in, more_in, dont_fragment,
// hop_limit, link_mtu, next_hop. The master stream gives one word per fragment
// or error, with tlast on the final word of the item and the result kind on tuser.
// A datagram that passes whole, or one refused for DF, is loaded into the output
// register straight after the fit check; an MTU at or below the header length is
// found by a second check, and a fragment count over the limit once the count
// passes MAX_FRAGMENTS. For a datagram cut into fragments the count is first
// found and checked, then each fragment takes a test step and a send step.
// Every step goes through the single 16-bit add/subtract unit. The block takes a
// new word only after the last result of the previous item is loaded.
// Reset is synchronous and active low; it empties the output register and
// returns the sequencer to idle. When the receiver stalls, the sequencer holds
// its next result until the output register frees up.
`timescale 1ns / 1ps

`include "ipv4_datagram_fragmenter_assert.svh"

module ipv4_datagram_fragmenter #(
    parameter int unsigned MAX_FRAGMENTS = ipv4f_pkg::MaxFragmentsDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // datagram_len[15:0], header_length[21:16], offset_in[37:22], more_in[38],
    // dont_fragment[39], hop_limit[47:40], link_mtu[63:48], next_hop[95:64]
    input  logic [ipv4f_pkg::InWidth-1:0]  s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // frag_length[15:0], frag_offset[31:16], more_out[32], hop_out[64:33],
    // zero fill [71:65]
    output logic [ipv4f_pkg::OutWidth-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    localparam int unsigned CntWidth = (MAX_FRAGMENTS > 2) ? $clog2(MAX_FRAGMENTS) : 1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FIT    = 9'b000000010,
        S_ONE    = 9'b000000100,
        S_STEP   = 9'b000001000,
        S_PAY    = 9'b000010000,
        S_COUNT  = 9'b000100000,
        S_RELOAD = 9'b001000000,
        S_TEST   = 9'b010000000,
        S_SEND   = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    logic [15:0]           r_total;
    logic [5:0]            r_hdr;
    logic [15:0]           r_off_in;
    logic                  r_more_in;
    logic                  r_df;
    logic [7:0]            r_hop_limit;
    logic [15:0]           r_mtu;
    logic [31:0]           r_next_hop;
    ipv4f_pkg::t_kind      r_kind, n_kind;
    logic [15:0]           r_step, n_step;
    logic [15:0]           r_rem, n_rem;
    logic [15:0]           r_off, n_off;
    logic [CntWidth-1:0]   r_cnt, n_cnt;
    logic                  r_is_last, n_is_last;

    ipv4f_pkg::t_alu_req   alu_req;
    ipv4f_pkg::t_alu_rsp   alu_rsp;
    ipv4f_pkg::t_result    out_word;
    ipv4f_pkg::t_result    reg_word;
    ipv4f_pkg::t_kind      send_kind;
    logic                  out_free;
    logic                  out_load;
    logic                  in_take;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign send_kind     = (r_hop_limit == 8'd0) ? ipv4f_pkg::K_TIME : ipv4f_pkg::K_SEND;

    // Capture the header word on acceptance.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_total     <= s_axis_tdata[15:0];
            r_hdr       <= s_axis_tdata[21:16];
            r_off_in    <= s_axis_tdata[37:22];
            r_more_in   <= s_axis_tdata[38];
            r_df        <= s_axis_tdata[39];
            r_hop_limit <= s_axis_tdata[47:40];
            r_mtu       <= s_axis_tdata[63:48];
            r_next_hop  <= s_axis_tdata[95:64];
        end
    end

    // Operand selection for the shared unit.
    always_comb begin
        alu_req.op = ipv4f_pkg::ALU_SUB;
        alu_req.a  = r_mtu;
        alu_req.b  = r_total;
        unique case (r_state)
            S_STEP: begin
                alu_req.b = {10'd0, r_hdr};
            end
            S_PAY, S_RELOAD: begin
                alu_req.a = r_total;
                alu_req.b = {10'd0, r_hdr};
            end
            S_COUNT, S_TEST: begin
                alu_req.a = r_rem;
                alu_req.b = r_step;
            end
            S_SEND: begin
                alu_req.op = ipv4f_pkg::ALU_ADD;
                alu_req.a  = r_is_last ? r_rem : r_off;
                alu_req.b  = r_is_last ? {10'd0, r_hdr} : r_step;
            end
            default: begin
                alu_req.op = ipv4f_pkg::ALU_SUB;
            end
        endcase
    end

    ipv4f_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Sequencer: classify, count fragments, then emit them.
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_step    = r_step;
        n_rem     = r_rem;
        n_off     = r_off;
        n_cnt     = r_cnt;
        n_is_last = r_is_last;
        out_load  = 1'b0;
        out_word.kind        = r_kind;
        out_word.frag_length = r_total;
        out_word.frag_offset = r_off_in;
        out_word.more_out    = r_more_in;
        out_word.hop_out     = r_next_hop;
        out_word.last        = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (!alu_rsp.borrow) begin
                    n_kind  = send_kind;
                    n_state = S_ONE;
                end else if (r_df) begin
                    n_kind  = ipv4f_pkg::K_FRAG_NEEDED;
                    n_state = S_ONE;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_ONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_STEP: begin
                // An MTU at or below the header length leaves no room for payload.
                if (alu_rsp.borrow || alu_rsp.zero) begin
                    n_kind  = ipv4f_pkg::K_TOO_MANY;
                    n_state = S_ONE;
                end else begin
                    n_step  = alu_rsp.result;
                    n_state = S_PAY;
                end
            end
            S_PAY: begin
                n_rem   = alu_rsp.result;
                n_cnt   = '0;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                if (alu_rsp.borrow || alu_rsp.zero) begin
                    n_state = S_RELOAD;
                end else if (r_cnt == CntWidth'(MAX_FRAGMENTS - 1)) begin
                    n_kind  = ipv4f_pkg::K_TOO_MANY;
                    n_state = S_ONE;
                end else begin
                    n_rem = alu_rsp.result;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RELOAD: begin
                n_rem   = alu_rsp.result;
                n_off   = 16'd0;
                n_kind  = send_kind;
                n_state = S_TEST;
            end
            S_TEST: begin
                n_is_last = alu_rsp.borrow || alu_rsp.zero;
                if (!(alu_rsp.borrow || alu_rsp.zero)) begin
                    n_rem = alu_rsp.result;
                end
                n_state = S_SEND;
            end
            S_SEND: begin
                // The last fragment carries the remaining payload plus header.
                out_word.frag_offset = r_off;
                out_word.last        = r_is_last;
                if (r_is_last) begin
                    out_word.frag_length = alu_rsp.result;
                end else begin
                    out_word.frag_length = r_mtu;
                    out_word.more_out    = 1'b1;
                end
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_off   = alu_rsp.result;
                        n_state = S_TEST;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_step    <= n_step;
        r_rem     <= n_rem;
        r_off     <= n_off;
        r_is_last <= n_is_last;
    end

    ipv4f_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_word        (out_word),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_word        (reg_word)
    );

    // Pack the held result onto the master stream.
    assign m_axis_tdata = {7'd0, reg_word.hop_out, reg_word.more_out,
                           reg_word.frag_offset, reg_word.frag_length};
    assign m_axis_tuser = reg_word.kind;
    assign m_axis_tlast = reg_word.last;

    // Checks on the sequencer.
    `IPV4F_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CntWidth'(MAX_FRAGMENTS - 1))
    `IPV4F_ASSERT(a_send_has_payload, i_clk, i_rst_n, (r_state == S_SEND) |-> (r_rem != 16'd0))
    `IPV4F_ASSERT(a_last_ends_item, i_clk, i_rst_n, (out_load && out_word.last) |=> (r_state == S_IDLE))
    `IPV4F_ASSERT(a_no_load_busy, i_clk, i_rst_n, out_load |-> out_free)
    `IPV4F_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !m_axis_tvalid))

endmodule
